// ===== src/ppe_pkg.sv =====
// Shared types, constants and register codes of the palette expander.
package ppe_pkg;

   // Default sizes of the palette store and of one row
   localparam int PPE_PALETTE_ENTRIES = 256;
   localparam int PPE_MAX_ROW_PIXELS  = 16384;

   // Widths of the register fields and the payload
   localparam int PPE_DEPTH_W = 4;
   localparam int PPE_COUNT_W = 9;
   localparam int PPE_ROW_W   = 15;
   localparam int PPE_CSR_W   = 15;
   localparam int PPE_CSR_A_W = 2;
   localparam int PPE_BYTE_W  = 8;
   localparam int PPE_RGB_W   = 24;

   // Register indexes
   localparam logic [PPE_CSR_A_W-1:0] CSR_SAMPLE_DEPTH  = 2'd0;
   localparam logic [PPE_CSR_A_W-1:0] CSR_PALETTE_COUNT = 2'd1;
   localparam logic [PPE_CSR_A_W-1:0] CSR_ALPHA_COUNT   = 2'd2;
   localparam logic [PPE_CSR_A_W-1:0] CSR_ROW_WIDTH     = 2'd3;

   // Register reset values
   localparam logic [PPE_DEPTH_W-1:0] RST_SAMPLE_DEPTH  = 4'd8;
   localparam logic [PPE_COUNT_W-1:0] RST_PALETTE_COUNT = 9'd0;
   localparam logic [PPE_COUNT_W-1:0] RST_ALPHA_COUNT   = 9'd0;
   localparam logic [PPE_ROW_W-1:0]   RST_ROW_WIDTH     = 15'd1;

   // Sample depth codes; any other code acts as eight bits
   localparam logic [PPE_DEPTH_W-1:0] DEPTH_1 = 4'd1;
   localparam logic [PPE_DEPTH_W-1:0] DEPTH_2 = 4'd2;
   localparam logic [PPE_DEPTH_W-1:0] DEPTH_4 = 4'd4;

   // Request operations
   localparam logic OP_WRITE_ENTRY = 1'b0;
   localparam logic OP_DATA_BYTE   = 1'b1;

   localparam logic [PPE_BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // Configuration seen by the unpacker
   typedef struct packed {
      logic [PPE_DEPTH_W-1:0] depth;
      logic [PPE_ROW_W-1:0]   row_width;
   } ppe_unpack_cfg_type;

   // One sample leaving the unpacker
   typedef struct packed {
      logic [PPE_BYTE_W-1:0] index;
      logic [PPE_BYTE_W-1:0] gray;
      logic                  row_end;
      logic                  last;
   } ppe_sample_type;

endpackage

// ===== src/packed_pixel_palette_expand.sv =====
// Top level of the packed pixel palette and gray depth expander.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   operation, palette entry, data byte
//   rsp      out        rsp_valid/rsp_ready   gray_or_red, green, blue, alpha, flags
//   csr      in         csr_we                csr_index, csr_wdata
//
// One pixel leaves per cycle while the response port is not stalled; the
// unpacker walks a data byte one sample per cycle, unless stalled, and drops
// the rest of a byte in which a row ends. The first pixel of a byte reaches
// the response port through the palette RAM read, then the output register.
// Reset clears the column counter, the pipeline valids and the registers;
// the palette RAMs hold nothing defined until written.
// A stalled response holds the pipeline; the next request is taken in the
// cycle the unpacker hands off the last sample of the current byte.
module packed_pixel_palette_expand
   import ppe_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PPE_PALETTE_ENTRIES,
   parameter int MAX_ROW_PIXELS  = PPE_MAX_ROW_PIXELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [PPE_BYTE_W-1:0]  req_entry_index,
   input  logic [PPE_BYTE_W-1:0]  req_entry_red,
   input  logic [PPE_BYTE_W-1:0]  req_entry_green,
   input  logic [PPE_BYTE_W-1:0]  req_entry_blue,
   input  logic [PPE_BYTE_W-1:0]  req_entry_alpha,
   input  logic [PPE_BYTE_W-1:0]  req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PPE_BYTE_W-1:0]  rsp_gray_or_red,
   output logic [PPE_BYTE_W-1:0]  rsp_green,
   output logic [PPE_BYTE_W-1:0]  rsp_blue,
   output logic [PPE_BYTE_W-1:0]  rsp_alpha,
   output logic                   rsp_row_end,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [PPE_CSR_A_W-1:0] csr_index,
   input  logic [PPE_CSR_W-1:0]   csr_wdata
);

   localparam int AddrW = $clog2(PALETTE_ENTRIES);

   // Configuration registers
   logic [PPE_DEPTH_W-1:0] depth_ff;
   logic [PPE_COUNT_W-1:0] pal_count_ff;
   logic [PPE_COUNT_W-1:0] alpha_count_ff;
   logic [PPE_ROW_W-1:0]   row_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff       <= RST_SAMPLE_DEPTH;
         pal_count_ff   <= RST_PALETTE_COUNT;
         alpha_count_ff <= RST_ALPHA_COUNT;
         row_width_ff   <= RST_ROW_WIDTH;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_DEPTH:  depth_ff       <= csr_wdata[PPE_DEPTH_W-1:0];
            CSR_PALETTE_COUNT: pal_count_ff   <= csr_wdata[PPE_COUNT_W-1:0];
            CSR_ALPHA_COUNT:   alpha_count_ff <= csr_wdata[PPE_COUNT_W-1:0];
            CSR_ROW_WIDTH:     row_width_ff   <= csr_wdata[PPE_ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Request acceptance
   logic               req_take, unp_free, unp_valid, unp_ready, load, pal_we;
   ppe_unpack_cfg_type unp_cfg;
   ppe_sample_type     smp;

   assign req_ready = unp_free;
   assign req_take  = req_valid && req_ready;
   assign load      = req_take && (req_operation == OP_DATA_BYTE);
   assign pal_we    = req_take && (req_operation == OP_WRITE_ENTRY) &&
                      ({1'b0, req_entry_index} < PPE_COUNT_W'(PALETTE_ENTRIES));

   assign unp_cfg.depth     = depth_ff;
   assign unp_cfg.row_width = row_width_ff;

   ppe_unpack #(
      .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
   ) u_unpack (
      .clock    (clock),
      .reset    (reset),
      .cfg      (unp_cfg),
      .load     (load),
      .load_byte(req_data_byte),
      .free     (unp_free),
      .smp_valid(unp_valid),
      .smp_ready(unp_ready),
      .smp      (smp)
   );

   // Clamp the index to the palette in use
   logic [PPE_COUNT_W-1:0] count_eff, idx_ext;
   logic [AddrW-1:0]       rd_addr;
   logic                   pal_mode, alpha_hit, rd_en;

   always_comb begin
      if (pal_count_ff > PPE_COUNT_W'(PALETTE_ENTRIES)) begin
         count_eff = PPE_COUNT_W'(PALETTE_ENTRIES);
      end else begin
         count_eff = pal_count_ff;
      end
      pal_mode = (count_eff != '0);
      idx_ext  = {1'b0, smp.index};
      if (pal_mode && (idx_ext >= count_eff)) begin
         idx_ext = count_eff - PPE_COUNT_W'(1);
      end
      alpha_hit = (idx_ext < alpha_count_ff);
      rd_addr   = idx_ext[AddrW-1:0];
   end

   // Palette stores
   logic                  s1_ready;
   logic [PPE_RGB_W-1:0]  rgb_rd;
   logic [PPE_BYTE_W-1:0] alpha_rd;

   assign unp_ready = s1_ready;
   assign rd_en     = unp_valid && unp_ready;

   ppe_ram #(
      .WIDTH(PPE_RGB_W),
      .DEPTH(PALETTE_ENTRIES)
   ) u_rgb_ram (
      .clock  (clock),
      .wr_en  (pal_we),
      .wr_addr(req_entry_index[AddrW-1:0]),
      .wr_data({req_entry_red, req_entry_green, req_entry_blue}),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rgb_rd)
   );

   ppe_ram #(
      .WIDTH(PPE_BYTE_W),
      .DEPTH(PALETTE_ENTRIES)
   ) u_alpha_ram (
      .clock  (clock),
      .wr_en  (pal_we),
      .wr_addr(req_entry_index[AddrW-1:0]),
      .wr_data(req_entry_alpha),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(alpha_rd)
   );

   // Read stage: hold the sample beside its RAM read
   logic                  s1_valid_ff, s1_pal_ff, s1_alpha_hit_ff;
   logic                  s1_row_end_ff, s1_last_ff, out_ready;
   logic [PPE_BYTE_W-1:0] s1_gray_ff;

   assign out_ready = !rsp_valid || rsp_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= unp_valid;
      end
      if (rd_en) begin
         s1_pal_ff       <= pal_mode;
         s1_alpha_hit_ff <= alpha_hit;
         s1_gray_ff      <= smp.gray;
         s1_row_end_ff   <= smp.row_end;
         s1_last_ff      <= smp.last;
      end
   end

   // Output register
   logic                  rsp_valid_ff, rsp_row_end_ff, rsp_last_ff;
   logic [PPE_BYTE_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (out_ready && s1_valid_ff) begin
         rsp_row_end_ff <= s1_row_end_ff;
         rsp_last_ff    <= s1_last_ff;
         if (s1_pal_ff) begin
            rsp_red_ff   <= rgb_rd[23:16];
            rsp_green_ff <= rgb_rd[15:8];
            rsp_blue_ff  <= rgb_rd[7:0];
            rsp_alpha_ff <= s1_alpha_hit_ff ? alpha_rd : ALPHA_OPAQUE;
         end else begin
            rsp_red_ff   <= s1_gray_ff;
            rsp_green_ff <= '0;
            rsp_blue_ff  <= '0;
            rsp_alpha_ff <= ALPHA_OPAQUE;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gray_or_red = rsp_red_ff;
   assign rsp_green       = rsp_green_ff;
   assign rsp_blue        = rsp_blue_ff;
   assign rsp_alpha       = rsp_alpha_ff;
   assign rsp_row_end     = rsp_row_end_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== src/ppe_ram.sv =====
// Generic single-port-write, registered-read RAM (read-first).
module ppe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read old contents on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ppe_unpack.sv =====
// Byte unpacker: splits a row byte into samples and tracks the row column.
module ppe_unpack
   import ppe_pkg::*;
#(
   parameter int MAX_ROW_PIXELS = PPE_MAX_ROW_PIXELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ppe_unpack_cfg_type    cfg,
   input  logic                  load,
   input  logic [PPE_BYTE_W-1:0] load_byte,
   output logic                  free,
   output logic                  smp_valid,
   input  logic                  smp_ready,
   output ppe_sample_type        smp
);

   localparam int ColW = $clog2(MAX_ROW_PIXELS + 1);
   localparam int CmpW = ((ColW > PPE_ROW_W) ? ColW : PPE_ROW_W) + 1;

   logic                  busy_ff, busy_in;
   logic [PPE_BYTE_W-1:0] byte_ff, byte_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic [ColW-1:0]       column_ff, column_in;

   logic [PPE_BYTE_W-1:0] shifted;
   logic [2:0]            cnt_init;
   logic [CmpW-1:0]       width_raw, width_max, width_eff, col_next;
   logic                  end_row, last_smp, advance;

   // Pick the top sample and its gray scaling by depth
   always_comb begin
      smp.row_end = end_row;
      smp.last    = last_smp;
      smp.index   = byte_ff;
      smp.gray    = byte_ff;
      shifted     = '0;
      cnt_init    = 3'd0;
      unique case (cfg.depth)
         DEPTH_1: begin
            smp.index = {7'd0, byte_ff[7]};
            smp.gray  = {8{byte_ff[7]}};
            shifted   = {byte_ff[6:0], 1'b0};
            cnt_init  = 3'd7;
         end
         DEPTH_2: begin
            smp.index = {6'd0, byte_ff[7:6]};
            smp.gray  = {4{byte_ff[7:6]}};
            shifted   = {byte_ff[5:0], 2'd0};
            cnt_init  = 3'd3;
         end
         DEPTH_4: begin
            smp.index = {4'd0, byte_ff[7:4]};
            smp.gray  = {2{byte_ff[7:4]}};
            shifted   = {byte_ff[3:0], 4'd0};
            cnt_init  = 3'd1;
         end
         default: begin
            smp.index = byte_ff;
            smp.gray  = byte_ff;
            shifted   = '0;
            cnt_init  = 3'd0;
         end
      endcase
   end

   // Clamp the row width and test for the row end
   always_comb begin
      width_raw = CmpW'(cfg.row_width);
      width_max = CmpW'(MAX_ROW_PIXELS);
      priority if (width_raw == '0) begin
         width_eff = CmpW'(1);
      end else if (width_raw > width_max) begin
         width_eff = width_max;
      end else begin
         width_eff = width_raw;
      end
      col_next = CmpW'(column_ff) + CmpW'(1);
      end_row  = (col_next >= width_eff);
   end

   assign last_smp    = end_row || (cnt_ff == 3'd0);
   assign smp_valid   = busy_ff;
   assign advance     = busy_ff && smp_ready;
   assign free        = !busy_ff || (smp_ready && last_smp);

   // Load a new byte, or shift out one sample per advance
   always_comb begin
      busy_in   = busy_ff;
      byte_in   = byte_ff;
      cnt_in    = cnt_ff;
      column_in = column_ff;
      if (advance) begin
         column_in = end_row ? '0 : ColW'(col_next);
         byte_in   = shifted;
         cnt_in    = cnt_ff - 3'd1;
         if (last_smp) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         byte_in = load_byte;
         cnt_in  = cnt_init;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         column_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         column_ff <= column_in;
      end
      byte_ff <= byte_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== dv/ppe_pixel_checker.sv =====
// Checker of the palette expander: tracks requests, predicts pixels, compares responses.
`timescale 1ns / 1ps

module ppe_pixel_checker
   import ppe_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PPE_PALETTE_ENTRIES,
   parameter int MAX_ROW_PIXELS  = PPE_MAX_ROW_PIXELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_operation,
   input  logic [PPE_BYTE_W-1:0]  req_entry_index,
   input  logic [PPE_BYTE_W-1:0]  req_entry_red,
   input  logic [PPE_BYTE_W-1:0]  req_entry_green,
   input  logic [PPE_BYTE_W-1:0]  req_entry_blue,
   input  logic [PPE_BYTE_W-1:0]  req_entry_alpha,
   input  logic [PPE_BYTE_W-1:0]  req_data_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [PPE_BYTE_W-1:0]  rsp_gray_or_red,
   input  logic [PPE_BYTE_W-1:0]  rsp_green,
   input  logic [PPE_BYTE_W-1:0]  rsp_blue,
   input  logic [PPE_BYTE_W-1:0]  rsp_alpha,
   input  logic                   rsp_row_end,
   input  logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [PPE_CSR_A_W-1:0] csr_index,
   input  logic [PPE_CSR_W-1:0]   csr_wdata,
   output int                     outstanding,
   output int                     mismatches
);

   typedef struct packed {
      logic [PPE_BYTE_W-1:0] gray_or_red;
      logic [PPE_BYTE_W-1:0] green;
      logic [PPE_BYTE_W-1:0] blue;
      logic [PPE_BYTE_W-1:0] alpha;
      logic                  row_end;
      logic                  last;
   } rgba_pixel_type;

   // Shadow of the palette, the row position and the registers
   logic [PPE_RGB_W-1:0]  shadow_rgb [PALETTE_ENTRIES];
   logic [PPE_BYTE_W-1:0] shadow_alpha [PALETTE_ENTRIES];
   int                    column;
   logic [PPE_DEPTH_W-1:0] depth_reg;
   logic [PPE_COUNT_W-1:0] count_reg;
   logic [PPE_COUNT_W-1:0] alpha_count_reg;
   logic [PPE_ROW_W-1:0]   width_reg;

   rgba_pixel_type pixels_due [$];
   int             error_count = 0;

   assign mismatches = error_count;

   // Unpack one data byte into the pixels it produces
   task automatic expand_byte(input logic [PPE_BYTE_W-1:0] data);
      int d;
      int per;
      int mask;
      int w;
      int cnt;
      int s;
      logic [PPE_RGB_W-1:0] rgb;
      rgba_pixel_type cur;
      rgba_pixel_type prev;
      if (depth_reg == DEPTH_1 || depth_reg == DEPTH_2 || depth_reg == DEPTH_4) begin
         d = int'(depth_reg);
      end else begin
         d = 8;
      end
      per  = 8 / d;
      mask = (1 << d) - 1;
      w    = int'(width_reg);
      if (w == 0) w = 1;
      if (w > MAX_ROW_PIXELS) w = MAX_ROW_PIXELS;
      cnt = int'(count_reg);
      if (cnt > PALETTE_ENTRIES) cnt = PALETTE_ENTRIES;
      prev = '0;
      for (int i = 0; i < per; i++) begin
         s = (int'(data) >> (8 - d * (i + 1))) & mask;
         if (cnt != 0) begin
            // Clamp the index to the last entry in use
            if (s >= cnt) s = cnt - 1;
            rgb             = shadow_rgb[s];
            cur.gray_or_red = rgb[23:16];
            cur.green       = rgb[15:8];
            cur.blue        = rgb[7:0];
            cur.alpha       = (s < int'(alpha_count_reg)) ? shadow_alpha[s] : ALPHA_OPAQUE;
         end else begin
            cur.gray_or_red = 8'((s * 255) / mask);
            cur.green       = '0;
            cur.blue        = '0;
            cur.alpha       = ALPHA_OPAQUE;
         end
         cur.row_end = (column + 1 >= w);
         cur.last    = 1'b0;
         column      = cur.row_end ? 0 : column + 1;
         if (i > 0) pixels_due.push_back(prev);
         prev = cur;
         // Drop the padding samples once the row is done
         if (cur.row_end) break;
      end
      prev.last = 1'b1;
      pixels_due.push_back(prev);
   endtask

   task automatic check_field(input string name, input int expv, input int actv);
      if (expv != actv) begin
         $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rgba_pixel_type want;
      if (reset) begin
         column          = 0;
         depth_reg       = RST_SAMPLE_DEPTH;
         count_reg       = RST_PALETTE_COUNT;
         alpha_count_reg = RST_ALPHA_COUNT;
         width_reg       = RST_ROW_WIDTH;
         pixels_due.delete();
      end else begin
         // Track register writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_SAMPLE_DEPTH: depth_reg = csr_wdata[PPE_DEPTH_W-1:0];
               CSR_PALETTE_COUNT: count_reg = csr_wdata[PPE_COUNT_W-1:0];
               CSR_ALPHA_COUNT: alpha_count_reg = csr_wdata[PPE_COUNT_W-1:0];
               CSR_ROW_WIDTH: width_reg = csr_wdata[PPE_ROW_W-1:0];
               default: ;
            endcase
         end
         // Predict from each accepted request
         if (req_valid && req_ready) begin
            if (req_operation == OP_WRITE_ENTRY) begin
               shadow_rgb[req_entry_index]   = {req_entry_red, req_entry_green, req_entry_blue};
               shadow_alpha[req_entry_index] = req_entry_alpha;
            end else begin
               expand_byte(req_data_byte);
            end
         end
         // Compare each accepted pixel with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (pixels_due.size() == 0) begin
               $error("unexpected pixel: gray_or_red %0d green %0d blue %0d alpha %0d",
                      rsp_gray_or_red, rsp_green, rsp_blue, rsp_alpha);
               error_count++;
            end else begin
               want = pixels_due.pop_front();
               check_field("gray_or_red", want.gray_or_red, rsp_gray_or_red);
               check_field("green", want.green, rsp_green);
               check_field("blue", want.blue, rsp_blue);
               check_field("alpha", want.alpha, rsp_alpha);
               check_field("row_end", want.row_end, rsp_row_end);
               check_field("last", want.last, rsp_last);
            end
         end
      end
      outstanding <= pixels_due.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top of the palette expander: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import ppe_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 8;

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   logic                   req_operation   = OP_DATA_BYTE;
   logic [PPE_BYTE_W-1:0]  req_entry_index = '0;
   logic [PPE_BYTE_W-1:0]  req_entry_red   = '0;
   logic [PPE_BYTE_W-1:0]  req_entry_green = '0;
   logic [PPE_BYTE_W-1:0]  req_entry_blue  = '0;
   logic [PPE_BYTE_W-1:0]  req_entry_alpha = '0;
   logic [PPE_BYTE_W-1:0]  req_data_byte   = '0;
   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b0;
   logic [PPE_BYTE_W-1:0]  rsp_gray_or_red;
   logic [PPE_BYTE_W-1:0]  rsp_green;
   logic [PPE_BYTE_W-1:0]  rsp_blue;
   logic [PPE_BYTE_W-1:0]  rsp_alpha;
   logic                   rsp_row_end;
   logic                   rsp_last;
   logic                   csr_we          = 1'b0;
   logic [PPE_CSR_A_W-1:0] csr_index       = CSR_SAMPLE_DEPTH;
   logic [PPE_CSR_W-1:0]   csr_wdata       = '0;

   int outstanding;
   int mismatches;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_ask      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   bit entry_written [PPE_PALETTE_ENTRIES];

   packed_pixel_palette_expand uut (.*);

   ppe_pixel_checker pixel_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Stall responses at random; hold off for a long stretch on request
   always @(posedge clock) begin
      if (hold_seen != hold_ask) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(input logic op, input logic [7:0] idx,
                               input logic [7:0] red, input logic [7:0] grn,
                               input logic [7:0] blu, input logic [7:0] alp,
                               input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_index <= idx;
      req_entry_red   <= red;
      req_entry_green <= grn;
      req_entry_blue  <= blu;
      req_entry_alpha <= alp;
      req_data_byte   <= data;
      if (op == OP_WRITE_ENTRY) entry_written[idx] = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_data(input logic [7:0] data);
      send_request(OP_DATA_BYTE, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), data);
   endtask

   task automatic send_entry(input logic [7:0] idx, input logic [7:0] red,
                             input logic [7:0] grn, input logic [7:0] blu,
                             input logic [7:0] alp);
      send_request(OP_WRITE_ENTRY, idx, red, grn, blu, alp, 8'($urandom));
   endtask

   task automatic send_random_entry(input logic [7:0] idx);
      send_entry(idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Drop valid and wait until every predicted pixel has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [PPE_CSR_A_W-1:0] idx,
                            input logic [PPE_CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Reprogram while idle, then load any palette entry that could be read
   task automatic configure(input logic [PPE_DEPTH_W-1:0] depth,
                            input logic [PPE_COUNT_W-1:0] pcount,
                            input logic [PPE_COUNT_W-1:0] acount,
                            input logic [PPE_ROW_W-1:0] width);
      int reach;
      int lim;
      drain();
      write_csr(CSR_SAMPLE_DEPTH, PPE_CSR_W'(depth));
      write_csr(CSR_PALETTE_COUNT, PPE_CSR_W'(pcount));
      write_csr(CSR_ALPHA_COUNT, PPE_CSR_W'(acount));
      write_csr(CSR_ROW_WIDTH, PPE_CSR_W'(width));
      csr_we <= 1'b0;
      // Only indexes a sample can hold, clamped to the palette, are read
      if (depth == DEPTH_1 || depth == DEPTH_2 || depth == DEPTH_4) begin
         reach = 1 << int'(depth);
      end else begin
         reach = 1 << PPE_BYTE_W;
      end
      lim = int'(pcount);
      if (lim > reach) lim = reach;
      for (int e = 0; e < lim && e < PPE_PALETTE_ENTRIES; e++) begin
         if (!entry_written[e]) send_random_entry(8'(e));
      end
   endtask

   initial begin
      logic [PPE_DEPTH_W-1:0] depth;
      logic [PPE_COUNT_W-1:0] pcount;
      logic [PPE_COUNT_W-1:0] acount;
      logic [PPE_ROW_W-1:0]   width;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, gray extremes
      send_idle_pct = 26;
      rsp_stall_pct = 26;
      send_data(8'h00);
      send_data(8'hFF);
      // Zero width acts as one: a row ends on the first sample
      configure(DEPTH_1, 9'd0, 9'd0, 15'd0);
      send_data(8'hA5);
      // Rows end on byte boundaries
      configure(DEPTH_1, 9'd0, 9'd0, 15'd16);
      send_data(8'hFF);
      send_data(8'h00);
      // Row ends inside a byte
      configure(DEPTH_2, 9'd0, 9'd0, 15'd5);
      send_data(8'hE4);
      send_data(8'h1B);
      send_data(8'hFF);
      // Odd depth code acts as eight bits
      configure(4'd3, 9'd0, 9'd0, 15'd3);
      send_data(8'h80);
      send_data(8'h7F);
      // Palette entries with extreme values
      send_entry(8'd0, 8'hFF, 8'h00, 8'hFF, 8'h00);
      send_entry(8'd1, 8'h00, 8'hFF, 8'h00, 8'hFF);
      send_entry(8'd3, 8'h55, 8'hAA, 8'h55, 8'hAA);
      send_entry(8'd255, 8'hAA, 8'h55, 8'hAA, 8'h55);
      // Index past the palette clamps; huge width saturates
      configure(DEPTH_2, 9'd2, 9'd1, 15'h7FFF);
      send_data(8'hE4);
      send_data(8'h1B);
      // Width lowered below the current column ends the row at once
      configure(DEPTH_2, 9'd2, 9'd1, 15'd2);
      send_data(8'h00);

      // Random phases over the settings and idling modes
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               depth = DEPTH_1; pcount = 9'd0; acount = 9'd0;
               width = 15'($urandom_range(1, 20));
               send_idle_pct = 0; rsp_stall_pct = 0;
            end
            1: begin
               depth = DEPTH_2; pcount = 9'd3; acount = 9'd2;
               width = 15'($urandom_range(1, 12));
               send_idle_pct = 51; rsp_stall_pct = 0;
            end
            2: begin
               depth = DEPTH_4; pcount = 9'd16; acount = 9'd9;
               width = 15'($urandom_range(2, 40));
               send_idle_pct = 0; rsp_stall_pct = 51;
            end
            3: begin
               depth = 4'd8; pcount = 9'd48; acount = 9'd24;
               width = 15'(PPE_MAX_ROW_PIXELS);
               send_idle_pct = 26; rsp_stall_pct = 26;
            end
            4: begin
               depth = DEPTH_2; pcount = 9'd511; acount = 9'd511; width = 15'd1;
               send_idle_pct = 0; rsp_stall_pct = 0;
            end
            5: begin
               depth = DEPTH_4; pcount = 9'd0; acount = 9'd300; width = 15'd3;
               send_idle_pct = 51; rsp_stall_pct = 0;
            end
            6: begin
               depth = DEPTH_1; pcount = 9'd2; acount = 9'd0;
               width = 15'($urandom_range(100, 300));
               send_idle_pct = 0; rsp_stall_pct = 51;
            end
            default: begin
               depth = 4'd0; pcount = 9'd1; acount = 9'd1; width = 15'd0;
               send_idle_pct = 26; rsp_stall_pct = 26;
            end
         endcase
         configure(depth, pcount, acount, width);
         // Hold off the receiver while the sender keeps pushing
         if (phase == 2) hold_ask <= hold_ask + 1;
         for (int n = 0; n < 26; n++) begin
            if ($urandom_range(99) < 12) begin
               send_random_entry(8'($urandom));
            end else begin
               send_data(8'($urandom));
            end
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
